### hdl/irr_pkg.sv
// Shared types and constants for the image region rotate core.
package irr_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int X_W        = $clog2(MAX_WIDTH);
   localparam int Y_W        = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = X_W + Y_W;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   localparam int PIX_W      = 24;
   localparam int CHAN_W     = 8;
   localparam int SIZE_W     = 10;
   localparam int COORD_W    = 12;
   localparam int OFF_W      = 14;
   localparam int TURN_W     = 2;
   localparam int REG_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int SETTLE_W   = 2;

   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd2;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_IMG_WIDTH  = 3'd0,
      REG_IMG_HEIGHT = 3'd1,
      REG_CORNER_AX  = 3'd2,
      REG_CORNER_AY  = 3'd3,
      REG_CORNER_BX  = 3'd4,
      REG_CORNER_BY  = 3'd5,
      REG_TURN       = 3'd6
   } reg_index_type;

   typedef enum logic [TURN_W-1:0] {
      TURN_90   = 2'd0,
      TURN_180  = 2'd1,
      TURN_270  = 2'd2,
      TURN_FULL = 2'd3
   } turn_type;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_READ  = 1'b1
   } cmd_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic [COORD_W-1:0]        sx;
      logic [COORD_W-1:0]        sy;
      logic signed [OFF_W-1:0]   dx;
      logic signed [OFF_W-1:0]   dy;
      logic [COORD_W-1:0]        cols;
      logic [COORD_W-1:0]        rows;
      logic                      remap_en;
      logic [SIZE_W-1:0]         w;
      logic [SIZE_W-1:0]         h;
      turn_type                  turn;
   } irr_geom_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  wdata;
   } irr_mem_req_type;

   typedef struct packed {
      logic read;
      logic zero;
   } irr_rsp_ctl_type;

endpackage

### hdl/irr_ram.sv
// Generic single-port RAM with registered read data.
module irr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end else if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/irr_geom.sv
// Configuration registers and registered region geometry.
module irr_geom (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [irr_pkg::REG_IDX_W-1:0]     csr_index,
   input  logic [irr_pkg::CSR_DATA_W-1:0]    csr_data,
   output irr_pkg::irr_geom_type             geom,
   output logic                              settling
);
   import irr_pkg::*;

   logic [SIZE_W-1:0]         img_width_ff, img_width_in;
   logic [SIZE_W-1:0]         img_height_ff, img_height_in;
   logic signed [COORD_W-1:0] ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   turn_type                  turn_ff, turn_in;
   logic [SETTLE_W-1:0]       settle_ff, settle_in;

   logic signed [COORD_W-1:0] left_ff, left_in, top_ff, top_in;
   logic [COORD_W-1:0]        sx_ff, sx_in, sy_ff, sy_in;
   logic [SIZE_W-1:0]         w_ff, w_in, h_ff, h_in;
   irr_geom_type              geom_ff, geom_in;

   logic                      write;
   logic signed [COORD_W-1:0] right, bottom;
   logic [COORD_W:0]          sx_full, sy_full;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      img_width_in  = img_width_ff;
      img_height_in = img_height_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      turn_in       = turn_ff;
      if (write) begin
         unique case (reg_index_type'(csr_index))
            REG_IMG_WIDTH:  img_width_in  = csr_data[SIZE_W-1:0];
            REG_IMG_HEIGHT: img_height_in = csr_data[SIZE_W-1:0];
            REG_CORNER_AX:  ax_in         = $signed(csr_data);
            REG_CORNER_AY:  ay_in         = $signed(csr_data);
            REG_CORNER_BX:  bx_in         = $signed(csr_data);
            REG_CORNER_BY:  by_in         = $signed(csr_data);
            REG_TURN:       turn_in       = turn_type'(csr_data[TURN_W-1:0]);
            default: ;
         endcase
      end
      if (write) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_comb begin
      left_in  = (ax_ff < bx_ff) ? ax_ff : bx_ff;
      right    = (ax_ff < bx_ff) ? bx_ff : ax_ff;
      top_in   = (ay_ff < by_ff) ? ay_ff : by_ff;
      bottom   = (ay_ff < by_ff) ? by_ff : ay_ff;
      sx_full  = {right[COORD_W-1], right} - {left_in[COORD_W-1], left_in};
      sy_full  = {bottom[COORD_W-1], bottom} - {top_in[COORD_W-1], top_in};
      sx_in    = sx_full[COORD_W-1:0];
      sy_in    = sy_full[COORD_W-1:0];
      w_in     = (img_width_ff > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : img_width_ff;
      h_in     = (img_height_ff > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : img_height_ff;
   end

   always_comb begin
      geom_in.left     = left_ff;
      geom_in.top      = top_ff;
      geom_in.sx       = sx_ff;
      geom_in.sy       = sy_ff;
      geom_in.w        = w_ff;
      geom_in.h        = h_ff;
      geom_in.turn     = turn_ff;
      geom_in.remap_en = (turn_ff != TURN_FULL) && (sx_ff != '0) && (sy_ff != '0);
      if (turn_ff == TURN_180) begin
         geom_in.dx   = OFF_W'(left_ff);
         geom_in.dy   = OFF_W'(top_ff);
         geom_in.cols = sx_ff;
         geom_in.rows = sy_ff;
      end else begin
         geom_in.dx   = OFF_W'(left_ff) + $signed({3'b000, sx_ff[COORD_W-1:1]})
                        - $signed({3'b000, sy_ff[COORD_W-1:1]});
         geom_in.dy   = OFF_W'(top_ff) + $signed({3'b000, sy_ff[COORD_W-1:1]})
                        - $signed({3'b000, sx_ff[COORD_W-1:1]});
         geom_in.cols = sy_ff;
         geom_in.rows = sx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= SIZE_W'(MAX_WIDTH);
         img_height_ff <= SIZE_W'(MAX_HEIGHT);
         ax_ff         <= '0;
         ay_ff         <= '0;
         bx_ff         <= '0;
         by_ff         <= '0;
         turn_ff       <= TURN_90;
         settle_ff     <= SETTLE_CYCLES;
      end else begin
         img_width_ff  <= img_width_in;
         img_height_ff <= img_height_in;
         ax_ff         <= ax_in;
         ay_ff         <= ay_in;
         bx_ff         <= bx_in;
         by_ff         <= by_in;
         turn_ff       <= turn_in;
         settle_ff     <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      top_ff  <= top_in;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      w_ff    <= w_in;
      h_ff    <= h_in;
      geom_ff <= geom_in;
   end

   assign geom     = geom_ff;
   assign settling = (settle_ff != '0);

endmodule

### hdl/irr_remap.sv
// Address remap: block test on transfer, source address and memory access next cycle.
module irr_remap (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          req_cmd,
   input  logic [irr_pkg::X_W-1:0]       req_pos_x,
   input  logic [irr_pkg::Y_W-1:0]       req_pos_y,
   input  logic [irr_pkg::PIX_W-1:0]     req_pix,
   input  irr_pkg::irr_geom_type         geom,
   output irr_pkg::irr_mem_req_type      mem_req,
   output irr_pkg::irr_rsp_ctl_type      rsp_ctl
);
   import irr_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   cmd_type             s1_cmd_ff;
   logic [X_W-1:0]      s1_px_ff;
   logic [Y_W-1:0]      s1_py_ff;
   logic [PIX_W-1:0]    s1_pix_ff;
   logic                s1_zero_ff, s1_zero_in;
   logic                s1_remap_ff, s1_remap_in;
   logic [COORD_W-1:0]  s1_i_ff, s1_j_ff;

   logic signed [OFF_W-1:0] row_off, col_off;
   logic                    outside, in_blk;
   logic [COORD_W-1:0]      ci, cj;
   logic signed [OFF_W-1:0] src_x, src_y;
   logic                    src_ok;

   always_comb begin
      row_off     = $signed({{(OFF_W-Y_W){1'b0}}, req_pos_y}) - geom.dy;
      col_off     = $signed({{(OFF_W-X_W){1'b0}}, req_pos_x}) - geom.dx;
      outside     = ({1'b0, req_pos_x} >= geom.w) || ({1'b0, req_pos_y} >= geom.h);
      in_blk      = !row_off[OFF_W-1] && (row_off[OFF_W-2:0] < {1'b0, geom.rows})
                    && !col_off[OFF_W-1] && (col_off[OFF_W-2:0] < {1'b0, geom.cols});
      s1_valid_in = accept;
      s1_zero_in  = outside;
      s1_remap_in = (cmd_type'(req_cmd) == CMD_READ) && in_blk && geom.remap_en && !outside;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff   <= cmd_type'(req_cmd);
      s1_px_ff    <= req_pos_x;
      s1_py_ff    <= req_pos_y;
      s1_pix_ff   <= req_pix;
      s1_zero_ff  <= s1_zero_in;
      s1_remap_ff <= s1_remap_in;
      s1_i_ff     <= row_off[COORD_W-1:0];
      s1_j_ff     <= col_off[COORD_W-1:0];
   end

   always_comb begin
      unique case (geom.turn)
         TURN_90: begin
            ci = s1_j_ff;
            cj = geom.sx - COORD_W'(1) - s1_i_ff;
         end
         TURN_180: begin
            ci = geom.sy - COORD_W'(1) - s1_i_ff;
            cj = geom.sx - COORD_W'(1) - s1_j_ff;
         end
         default: begin
            ci = geom.sy - COORD_W'(1) - s1_j_ff;
            cj = s1_i_ff;
         end
      endcase
      src_x  = OFF_W'(geom.left) + $signed({2'b00, cj});
      src_y  = OFF_W'(geom.top) + $signed({2'b00, ci});
      src_ok = !src_x[OFF_W-1] && (src_x[OFF_W-2:0] < {3'b000, geom.w})
               && !src_y[OFF_W-1] && (src_y[OFF_W-2:0] < {3'b000, geom.h});
   end

   always_comb begin
      mem_req.wr_en = s1_valid_ff && (s1_cmd_ff == CMD_WRITE);
      mem_req.rd_en = s1_valid_ff && (s1_cmd_ff == CMD_READ);
      mem_req.addr  = s1_remap_ff ? {src_y[Y_W-1:0], src_x[X_W-1:0]} : {s1_py_ff, s1_px_ff};
      mem_req.wdata = s1_pix_ff;
      rsp_ctl.read  = mem_req.rd_en;
      rsp_ctl.zero  = s1_zero_ff || (s1_remap_ff && !src_ok);
   end

   a_stage_follows_transfer: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(accept))
      else $error("memory access without a preceding transfer");

endmodule

### hdl/image_region_rotate_core.sv
// Image region rotate core: frame store with a turned rectangle on reads.
//
// The core takes one command per clock cycle whenever busy is low; a pixel
// write lands in the frame store in the cycle after its transfer, and a read
// answers on rsp_valid after the address remap stage and the registered read
// of the single-port frame store, in command order, with no way to stall the
// answer. The frame store serves one write or one read per cycle. Busy rises
// after reset and after every register write while the region geometry is
// recomputed. Pixels never written since reset read back with undefined
// values; the store is not cleared.
module image_region_rotate_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_cmd,
   input  logic [irr_pkg::X_W-1:0]        req_pos_x,
   input  logic [irr_pkg::Y_W-1:0]        req_pos_y,
   input  logic [irr_pkg::CHAN_W-1:0]     req_red_in,
   input  logic [irr_pkg::CHAN_W-1:0]     req_green_in,
   input  logic [irr_pkg::CHAN_W-1:0]     req_blue_in,
   output logic                           rsp_valid,
   output logic [irr_pkg::CHAN_W-1:0]     rsp_red_out,
   output logic [irr_pkg::CHAN_W-1:0]     rsp_green_out,
   output logic [irr_pkg::CHAN_W-1:0]     rsp_blue_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [irr_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [irr_pkg::CSR_DATA_W-1:0] csr_data
);
   import irr_pkg::*;

   irr_geom_type    geom;
   irr_mem_req_type mem_req;
   irr_rsp_ctl_type rsp_ctl;
   logic            settling;
   logic            accept;
   logic [PIX_W-1:0] rdata;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            zero_ff;

   assign busy   = settling;
   assign accept = start && !busy;

   irr_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom),
      .settling  (settling)
   );

   irr_remap u_remap (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_cmd   (req_cmd),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .req_pix   ({req_red_in, req_green_in, req_blue_in}),
      .geom      (geom),
      .mem_req   (mem_req),
      .rsp_ctl   (rsp_ctl)
   );

   irr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock (clock),
      .wr_en (mem_req.wr_en),
      .rd_en (mem_req.rd_en),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (rdata)
   );

   assign rsp_valid_in = rsp_ctl.read;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= rsp_ctl.zero;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = zero_ff ? '0 : rdata[PIX_W-1 -: CHAN_W];
   assign rsp_green_out = zero_ff ? '0 : rdata[2*CHAN_W-1 -: CHAN_W];
   assign rsp_blue_out  = zero_ff ? '0 : rdata[CHAN_W-1:0];

   a_busy_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> busy)
      else $error("command taken while geometry is stale");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && (req_cmd == CMD_READ), 2))
      else $error("response without a read transfer two cycles earlier");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == CMD_WRITE) |-> ##2 !rsp_valid)
      else $error("pixel write produced a response");

endmodule

### tb/tb_image_region_rotate_core.sv
// Testbench for image_region_rotate_core: pixel writes and turned-region reads checked in order.
module tb_image_region_rotate_core;
   import irr_pkg::*;

   localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;
   localparam int SETTLE = 6;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_cmd;
   logic [X_W-1:0]        req_pos_x;
   logic [Y_W-1:0]        req_pos_y;
   logic [CHAN_W-1:0]     req_red_in;
   logic [CHAN_W-1:0]     req_green_in;
   logic [CHAN_W-1:0]     req_blue_in;
   logic                  rsp_valid;
   logic [CHAN_W-1:0]     rsp_red_out;
   logic [CHAN_W-1:0]     rsp_green_out;
   logic [CHAN_W-1:0]     rsp_blue_out;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [REG_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   image_region_rotate_core u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   logic [SIZE_W-1:0]         cur_width  = 10'd512;
   logic [SIZE_W-1:0]         cur_height = 10'd512;
   logic signed [COORD_W-1:0] cur_ax     = '0;
   logic signed [COORD_W-1:0] cur_ay     = '0;
   logic signed [COORD_W-1:0] cur_bx     = '0;
   logic signed [COORD_W-1:0] cur_by     = '0;
   turn_type                  cur_turn   = TURN_90;

   logic [PIX_W-1:0] pix_mirror [int];
   logic [PIX_W-1:0] pending_pixels [$];

   bit gaps_on    = 1'b1;
   int fail_count = 0;
   int n_writes   = 0;
   int n_reads    = 0;
   int n_settings = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [CSR_DATA_W-1:0] to_word(input int v);
      return v[CSR_DATA_W-1:0];
   endfunction

   function automatic logic [CHAN_W-1:0] rand_chan();
      return CHAN_W'($urandom_range(0, 255));
   endfunction

   // Store address that a read at (x, y) fetches; zero when it fetches nothing.
   function automatic bit map_source(input int x, input int y, output int addr);
      int w, h, ax, ay, bx, by, left, top, sx, sy, dx, dy, cols, rows;
      int i, j, ci, cj, fx, fy;
      addr = 0;
      w  = (cur_width > MAX_WIDTH) ? MAX_WIDTH : int'(cur_width);
      h  = (cur_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cur_height);
      if (x >= w || y >= h) return 1'b0;
      ax = cur_ax;
      ay = cur_ay;
      bx = cur_bx;
      by = cur_by;
      fx = x;
      fy = y;
      left = (ax < bx) ? ax : bx;
      sx   = ((ax < bx) ? bx : ax) - left;
      top  = (ay < by) ? ay : by;
      sy   = ((ay < by) ? by : ay) - top;
      if (cur_turn != TURN_FULL && sx > 0 && sy > 0) begin
         if (cur_turn == TURN_180) begin
            dx = left;
            dy = top;
            cols = sx;
            rows = sy;
         end else begin
            dx = left + sx / 2 - sy / 2;
            dy = top + sy / 2 - sx / 2;
            cols = sy;
            rows = sx;
         end
         i = y - dy;
         j = x - dx;
         if (i >= 0 && i < rows && j >= 0 && j < cols) begin
            if (cur_turn == TURN_90) begin
               ci = j;
               cj = sx - 1 - i;
            end else if (cur_turn == TURN_180) begin
               ci = sy - 1 - i;
               cj = sx - 1 - j;
            end else begin
               ci = sy - 1 - j;
               cj = i;
            end
            fx = left + cj;
            fy = top + ci;
         end
      end
      if (fx < 0 || fy < 0 || fx >= w || fy >= h) return 1'b0;
      addr = fy * MAX_WIDTH + fx;
      return 1'b1;
   endfunction

   task automatic send_item(input cmd_type cmd, input int x, input int y,
                            input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b);
      int addr;
      logic [PIX_W-1:0] pix;
      if (gaps_on && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start        <= 1'b1;
      req_cmd      <= cmd;
      req_pos_x    <= x[X_W-1:0];
      req_pos_y    <= y[Y_W-1:0];
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      do @(posedge clock); while (busy !== 1'b0);
      if (cmd == CMD_WRITE) begin
         pix_mirror[y * MAX_WIDTH + x] = {r, g, b};
         n_writes++;
      end else begin
         pix = '0;
         if (map_source(x, y, addr)) pix = pix_mirror[addr];
         pending_pixels.push_back(pix);
         n_reads++;
      end
   endtask

   // Fill the fetched pixel first if it was never written.
   task automatic send_read(input int x, input int y);
      int addr;
      if (map_source(x, y, addr) && !pix_mirror.exists(addr))
         send_item(CMD_WRITE, addr % MAX_WIDTH, addr / MAX_WIDTH, rand_chan(),
                   rand_chan(), rand_chan());
      send_item(CMD_READ, x, y, rand_chan(), rand_chan(), rand_chan());
   endtask

   task automatic hold_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   task automatic csr_transfer(input logic [REG_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         REG_IMG_WIDTH:  cur_width  = data[SIZE_W-1:0];
         REG_IMG_HEIGHT: cur_height = data[SIZE_W-1:0];
         REG_CORNER_AX:  cur_ax     = data;
         REG_CORNER_AY:  cur_ay     = data;
         REG_CORNER_BX:  cur_bx     = data;
         REG_CORNER_BY:  cur_by     = data;
         REG_TURN:       cur_turn   = turn_type'(data[TURN_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic program_registers(input logic [CSR_DATA_W-1:0] wd, ht, ax, ay, bx, by, tn);
      hold_until_drained();
      repeat (SETTLE) @(posedge clock);
      csr_transfer(REG_IMG_WIDTH, wd);
      csr_transfer(REG_IMG_HEIGHT, ht);
      csr_transfer(REG_CORNER_AX, ax);
      csr_transfer(REG_CORNER_AY, ay);
      csr_transfer(REG_CORNER_BX, bx);
      csr_transfer(REG_CORNER_BY, by);
      csr_transfer(REG_TURN, tn);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   task automatic run_traffic(input int count);
      int lim_w, lim_h, x, y;
      lim_w = (cur_width > MAX_WIDTH) ? MAX_WIDTH : int'(cur_width);
      lim_h = (cur_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cur_height);
      if (lim_w == 0) lim_w = 1;
      if (lim_h == 0) lim_h = 1;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 39) == 0) hold_until_drained();
         if ($urandom_range(0, 99) < 30) begin
            if ($urandom_range(0, 99) < 85) begin
               x = $urandom_range(0, lim_w - 1);
               y = $urandom_range(0, lim_h - 1);
            end else begin
               x = $urandom_range(0, MAX_WIDTH - 1);
               y = $urandom_range(0, MAX_HEIGHT - 1);
            end
            send_item(CMD_WRITE, x, y, rand_chan(), rand_chan(), rand_chan());
         end else begin
            if ($urandom_range(0, 9) == 0) begin
               x = $urandom_range(0, MAX_WIDTH - 1);
               y = $urandom_range(0, MAX_HEIGHT - 1);
            end else begin
               x = $urandom_range(0, lim_w + 1);
               y = $urandom_range(0, lim_h + 1);
               if (x >= MAX_WIDTH) x = MAX_WIDTH - 1;
               if (y >= MAX_HEIGHT) y = MAX_HEIGHT - 1;
            end
            send_read(x, y);
         end
      end
   endtask

   task automatic test_defaults();
      send_item(CMD_WRITE, 0, 0, 8'hFF, 8'h00, 8'hAA);
      send_item(CMD_WRITE, 511, 511, 8'h00, 8'hFF, 8'h55);
      send_read(0, 0);
      send_read(511, 511);
   endtask

   task automatic test_edge_cases();
      turn_type turns [4];
      turns = '{TURN_90, TURN_180, TURN_270, TURN_FULL};
      foreach (turns[t]) begin
         program_registers(12'hC08, to_word(8), to_word(6), to_word(4), to_word(1),
                           to_word(1), to_word(int'(turns[t])));
         send_read(2, 0);
         send_read(3, 2);
         send_read(5, 3);
      end
      send_item(CMD_WRITE, 300, 300, 8'hFF, 8'hFF, 8'hFF);
      program_registers(to_word(0), to_word(8), to_word(1), to_word(1), to_word(6),
                        to_word(4), to_word(int'(TURN_90)));
      send_read(0, 0);
      program_registers(12'h3FF, to_word(301), to_word(0), to_word(0), to_word(0),
                        to_word(0), to_word(int'(TURN_90)));
      send_read(300, 300);
      send_read(0, 301);
      send_read(511, 0);
      program_registers(to_word(4), to_word(4), 12'h800, 12'h800, 12'h7FF, 12'h7FF,
                        to_word(int'(TURN_270)));
      send_read(0, 0);
      send_read(3, 3);
      program_registers(to_word(8), to_word(8), to_word(2), to_word(0), to_word(2),
                        to_word(5), to_word(int'(TURN_180)));
      send_read(2, 2);
      hold_until_drained();
      repeat (SETTLE) @(posedge clock);
      csr_transfer(REG_SPARE, 12'hFFF);
      csr_valid <= 1'b0;
      send_read(2, 2);
   endtask

   task automatic test_random_regions();
      int kind, w, h, t;
      logic [CSR_DATA_W-1:0] wd, ht, ax, ay, bx, by;
      for (int phase = 0; phase < 16; phase++) begin
         kind = $urandom_range(0, 4);
         t = ($urandom_range(0, 15) == 0) ? int'(TURN_FULL) : $urandom_range(0, 2);
         if (kind == 0) begin
            wd = CSR_DATA_W'($urandom);
            ht = CSR_DATA_W'($urandom);
            ax = CSR_DATA_W'($urandom);
            ay = CSR_DATA_W'($urandom);
            bx = CSR_DATA_W'($urandom);
            by = CSR_DATA_W'($urandom);
         end else if (kind == 1) begin
            wd = to_word(512 | ($urandom_range(0, 3) << 10));
            ht = to_word(512);
            ax = to_word($urandom_range(0, 511));
            ay = to_word($urandom_range(0, 511));
            bx = to_word($urandom_range(0, 511));
            by = to_word($urandom_range(0, 511));
         end else begin
            w  = $urandom_range(1, 24);
            h  = $urandom_range(1, 24);
            wd = to_word(w | ($urandom_range(0, 3) << 10));
            ht = to_word(h | ($urandom_range(0, 3) << 10));
            ax = to_word(int'($urandom_range(0, w + 6)) - 3);
            ay = to_word(int'($urandom_range(0, h + 6)) - 3);
            bx = to_word(int'($urandom_range(0, w + 6)) - 3);
            by = to_word(int'($urandom_range(0, h + 6)) - 3);
         end
         program_registers(wd, ht, ax, ay, bx, by,
                           to_word(($urandom_range(0, 1023) << 2) | t));
         run_traffic(50);
      end
   endtask

   task automatic test_streaming();
      program_registers(to_word(16), to_word(12), to_word(13), to_word(2), to_word(3),
                        to_word(7), to_word(int'(TURN_270)));
      gaps_on = 1'b0;
      run_traffic(60);
      hold_until_drained();
      run_traffic(60);
      gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin
      logic [PIX_W-1:0] want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            $error("rsp_valid with no read outstanding");
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_red_out !== want[23:16]) begin
               $error("red_out: expected %02h, got %02h", want[23:16], rsp_red_out);
               fail_count++;
            end
            if (rsp_green_out !== want[15:8]) begin
               $error("green_out: expected %02h, got %02h", want[15:8], rsp_green_out);
               fail_count++;
            end
            if (rsp_blue_out !== want[7:0]) begin
               $error("blue_out: expected %02h, got %02h", want[7:0], rsp_blue_out);
               fail_count++;
            end
         end
      end
   end

   initial begin
      reset        <= 1'b1;
      start        <= 1'b0;
      req_cmd      <= CMD_WRITE;
      req_pos_x    <= '0;
      req_pos_y    <= '0;
      req_red_in   <= '0;
      req_green_in <= '0;
      req_blue_in  <= '0;
      csr_valid    <= 1'b0;
      csr_index    <= REG_IMG_WIDTH;
      csr_data     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_defaults();
      test_edge_cases();
      test_random_regions();
      test_streaming();
      hold_until_drained();
      repeat (SETTLE) @(posedge clock);
      $display("Covered %0d pixel writes and %0d reads over %0d region settings,",
               n_writes, n_reads, n_settings);
      $display("including every turn code, empty and clipped regions and zero-size images.");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
